FILE: hw/rtl/cartridge_bank_mapper_with_irq_and_tones_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cartridge bank mapper
// Concurrent checks on the block clock; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_AND_TONES_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_AND_TONES_MACROS_SVH

`ifndef SYNTHESIS
`define CBM_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define CBM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define CBM_ASSERT_SAME(lbl, ante, cons)
`define CBM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types, codes and the volume table of the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

	localparam int CHR_SLOTS         = 8;
	localparam int TONE_CHANNELS_DEF = 3;
	localparam int VOL_FRAC_BITS_DEF = 8;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_FETCH = 2'd2,
		KIND_TICK  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		TGT_NONE = 3'd0,
		TGT_ZERO = 3'd1,
		TGT_WRAM = 3'd2,
		TGT_PRG  = 3'd3,
		TGT_CHR  = 3'd4
	} target_t;

	// CPU address regions, address bits 15..13
	localparam logic [2:0] RGN_WRAM     = 3'd3;
	localparam logic [2:0] RGN_CMD_SEL  = 3'd4;
	localparam logic [2:0] RGN_CMD_DATA = 3'd5;
	localparam logic [2:0] RGN_AUD_SEL  = 3'd6;
	localparam logic [2:0] RGN_AUD_DATA = 3'd7;

	// command latch codes
	localparam logic [3:0] CMD_CHR_FIRST = 4'd0;
	localparam logic [3:0] CMD_CHR_LAST  = 4'd7;
	localparam logic [3:0] CMD_RAM_MODE  = 4'd8;
	localparam logic [3:0] CMD_PRG0      = 4'd9;
	localparam logic [3:0] CMD_PRG1      = 4'd10;
	localparam logic [3:0] CMD_PRG2      = 4'd11;
	localparam logic [3:0] CMD_MIRROR    = 4'd12;
	localparam logic [3:0] CMD_IRQ_CTRL  = 4'd13;
	localparam logic [3:0] CMD_IRQ_LO    = 4'd14;
	localparam logic [3:0] CMD_IRQ_HI    = 4'd15;

	// audio select codes
	localparam logic [3:0] SEL_PERIOD_LAST = 4'd5;
	localparam logic [3:0] SEL_ENABLE      = 4'd7;
	localparam logic [3:0] SEL_VOL_FIRST   = 4'd8;
	localparam logic [3:0] SEL_VOL_LAST    = 4'd10;

	// configuration register indexes
	localparam logic CFG_PRG_LOG2 = 1'b0;
	localparam logic CFG_CHR_LOG2 = 1'b1;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] address;
		logic [7:0]  value;
		logic [1:0]  cycles;
	} item_t;

	typedef struct packed {
		logic       ctrl_we;
		logic       lo_we;
		logic       hi_we;
		logic [7:0] data;
	} irq_wr_t;

	function automatic logic [15:0] vol_q8(input logic [3:0] idx);
		logic [15:0] v;
		case (idx)
			4'd0:    v = 16'd0;
			4'd1:    v = 16'd362;
			4'd2:    v = 16'd511;
			4'd3:    v = 16'd722;
			4'd4:    v = 16'd1019;
			4'd5:    v = 16'd1440;
			4'd6:    v = 16'd2033;
			4'd7:    v = 16'd2872;
			4'd8:    v = 16'd4057;
			4'd9:    v = 16'd5731;
			4'd10:   v = 16'd8095;
			4'd11:   v = 16'd11435;
			4'd12:   v = 16'd16153;
			4'd13:   v = 16'd22816;
			4'd14:   v = 16'd32228;
			default: v = 16'd45524;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/cbm_map.sv
// ----------------------------------------------------------------------------
// cbm_map
// Command latch, bank, RAM mode and mirroring registers; address mapping.
// ----------------------------------------------------------------------------
module cbm_map (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  cbm_pkg::item_t   item,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [3:0]       cfg_data,
	output logic [2:0]       target,
	output logic [18:0]      rom_address,
	output logic [1:0]       mirroring,
	output cbm_pkg::irq_wr_t irq_wr
);
	import cbm_pkg::*;

	logic [2:0] prg_log2_q;
	logic [3:0] chr_log2_q;
	logic [3:0] latch_q;
	logic [7:0] ram_mode_q;
	logic [7:0] prg_bank_q [3];
	logic [7:0] chr_bank_q [CHR_SLOTS];
	logic [1:0] mirror_q;

	logic [2:0] rgn;
	logic       is_write;
	logic       cmd_wr;
	logic [2:0] prg_lg;
	logic [5:0] prg_mask;
	logic [3:0] chr_lg;
	logic [7:0] chr_mask;
	logic [7:0] prg_sel;
	logic [7:0] chr_sel;

	assign rgn      = item.address[15:13];
	assign is_write = (item.kind == KIND_WRITE);
	assign cmd_wr   = is_write && (rgn == RGN_CMD_DATA);
	assign prg_lg   = (prg_log2_q > 3'd6) ? 3'd6 : prg_log2_q;
	assign prg_mask = 6'((7'd1 << prg_lg) - 7'd1);
	assign chr_lg   = (chr_log2_q > 4'd8) ? 4'd8 : chr_log2_q;
	assign chr_mask = 8'((9'd1 << chr_lg) - 9'd1);
	assign chr_sel  = chr_bank_q[item.address[12:10]];

	always_comb begin
		case (item.address[14:13])
			2'd0:    prg_sel = prg_bank_q[0];
			2'd1:    prg_sel = prg_bank_q[1];
			2'd2:    prg_sel = prg_bank_q[2];
			default: prg_sel = 8'hFF;
		endcase
	end

	always_comb begin
		target      = TGT_NONE;
		rom_address = '0;
		unique case (item.kind)
			KIND_WRITE: begin
				if (rgn == RGN_WRAM && ram_mode_q[7:6] == 2'b11) begin
					target = TGT_WRAM;
				end
			end
			KIND_READ: begin
				if (item.address[15]) begin
					target      = TGT_PRG;
					rom_address = {prg_sel[5:0] & prg_mask, item.address[12:0]};
				end else if (rgn == RGN_WRAM) begin
					if (ram_mode_q[6]) begin
						target = ram_mode_q[7] ? TGT_WRAM : TGT_ZERO;
					end else begin
						target      = TGT_PRG;
						rom_address = {ram_mode_q[5:0] & prg_mask, item.address[12:0]};
					end
				end
			end
			KIND_FETCH: begin
				target      = TGT_CHR;
				rom_address = {1'b0, chr_sel & chr_mask, item.address[9:0]};
			end
			default: begin
			end
		endcase
	end

	assign mirroring = (cmd_wr && latch_q == CMD_MIRROR) ? item.value[1:0] : mirror_q;

	assign irq_wr.ctrl_we = cmd_wr && (latch_q == CMD_IRQ_CTRL);
	assign irq_wr.lo_we   = cmd_wr && (latch_q == CMD_IRQ_LO);
	assign irq_wr.hi_we   = cmd_wr && (latch_q == CMD_IRQ_HI);
	assign irq_wr.data    = item.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_log2_q <= 3'd5;
			chr_log2_q <= 4'd8;
		end else if (cfg_we) begin
			if (cfg_index == CFG_PRG_LOG2) begin
				prg_log2_q <= cfg_data[2:0];
			end else begin
				chr_log2_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q       <= '0;
			ram_mode_q    <= '0;
			prg_bank_q[0] <= 8'd0;
			prg_bank_q[1] <= 8'd0;
			prg_bank_q[2] <= 8'd1;
			for (int i = 0; i < CHR_SLOTS; i++) begin
				chr_bank_q[i] <= 8'(i);
			end
			mirror_q      <= '0;
		end else if (advance) begin
			mirror_q <= mirroring;
			if (is_write && rgn == RGN_CMD_SEL) begin
				latch_q <= item.value[3:0];
			end
			if (cmd_wr) begin
				unique case (latch_q) inside
					[CMD_CHR_FIRST:CMD_CHR_LAST]: chr_bank_q[latch_q[2:0]] <= item.value;
					CMD_RAM_MODE: ram_mode_q    <= item.value;
					CMD_PRG0:     prg_bank_q[0] <= item.value;
					CMD_PRG1:     prg_bank_q[1] <= item.value;
					CMD_PRG2:     prg_bank_q[2] <= item.value;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

FILE: hw/rtl/cbm_irq.sv
// ----------------------------------------------------------------------------
// cbm_irq
// 16-bit down-counting IRQ timer stepped once every three master cycles.
// ----------------------------------------------------------------------------
module cbm_irq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  cbm_pkg::item_t   item,
	input  cbm_pkg::irq_wr_t irq_wr,
	output logic             irq_line
);
	import cbm_pkg::*;

	logic [1:0]  ctrl_q;
	logic [15:0] count_q;
	logic        pending_q;
	logic [1:0]  prescale_q;

	logic [2:0]  t_sum;
	logic        step;
	logic [1:0]  ctrl_d;
	logic [15:0] count_d;
	logic        pending_d;
	logic [1:0]  prescale_d;

	assign t_sum = {1'b0, prescale_q} + {1'b0, item.cycles};
	assign step  = (item.kind == KIND_TICK) && (t_sum > 3'd2);

	always_comb begin
		ctrl_d     = ctrl_q;
		count_d    = count_q;
		pending_d  = pending_q;
		prescale_d = prescale_q;
		if (irq_wr.ctrl_we) begin
			ctrl_d    = {irq_wr.data[7], irq_wr.data[0]};
			pending_d = 1'b0;
		end
		if (irq_wr.lo_we) begin
			count_d = {count_q[15:8], irq_wr.data};
		end
		if (irq_wr.hi_we) begin
			count_d = {irq_wr.data, count_q[7:0]};
		end
		if (item.kind == KIND_TICK) begin
			prescale_d = step ? 2'(t_sum - 3'd3) : t_sum[1:0];
			if (step && ctrl_q[1]) begin
				count_d = count_q - 16'd1;
				if (count_q == 16'd0 && ctrl_q[0]) begin
					pending_d = 1'b1;
				end
			end
		end
	end

	assign irq_line = pending_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q     <= '0;
			count_q    <= '0;
			pending_q  <= 1'b0;
			prescale_q <= '0;
		end else if (advance) begin
			ctrl_q     <= ctrl_d;
			count_q    <= count_d;
			pending_q  <= pending_d;
			prescale_q <= prescale_d;
		end
	end

endmodule

FILE: hw/rtl/cbm_tone.sv
// ----------------------------------------------------------------------------
// cbm_tone
// Square tone generators stepped once every six master cycles; level sum.
// ----------------------------------------------------------------------------
module cbm_tone #(
	parameter int TONE_CHANNELS = cbm_pkg::TONE_CHANNELS_DEF,
	parameter int VOL_FRAC_BITS = cbm_pkg::VOL_FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  cbm_pkg::item_t item,
	output logic [17:0]    audio_level
);
	import cbm_pkg::*;

	localparam int UP_SHIFT = (VOL_FRAC_BITS >= 8) ? (VOL_FRAC_BITS - 8) : 0;
	localparam int DN_SHIFT = (VOL_FRAC_BITS < 8) ? (8 - VOL_FRAC_BITS) : 0;
	localparam logic [31:0] DN_HALF = 32'((1 << DN_SHIFT) >> 1);

	logic [3:0]  select_q;
	logic [2:0]  prescale_q;
	logic [11:0] period_q  [TONE_CHANNELS];
	logic        enable_q  [TONE_CHANNELS];
	logic [3:0]  volume_q  [TONE_CHANNELS];
	logic [11:0] counter_q [TONE_CHANNELS];
	logic [3:0]  phase_q   [TONE_CHANNELS];

	logic [11:0] period_d  [TONE_CHANNELS];
	logic        enable_d  [TONE_CHANNELS];
	logic [3:0]  volume_d  [TONE_CHANNELS];
	logic [11:0] counter_d [TONE_CHANNELS];
	logic [3:0]  phase_d   [TONE_CHANNELS];

	logic [2:0]  rgn;
	logic        data_wr;
	logic [3:0]  select_d;
	logic [3:0]  t_sum;
	logic        step;
	logic [2:0]  prescale_d;
	logic [12:0] next_cnt  [TONE_CHANNELS];
	logic [31:0] level_acc;

	function automatic logic [31:0] vol_scaled(input logic [3:0] idx);
		logic [31:0] v;
		v = {16'd0, vol_q8(idx)};
		if (VOL_FRAC_BITS >= 8) begin
			return v << UP_SHIFT;
		end
		return (v + DN_HALF) >> DN_SHIFT;
	endfunction

	assign rgn      = item.address[15:13];
	assign data_wr  = (item.kind == KIND_WRITE) && (rgn == RGN_AUD_DATA);
	assign select_d = ((item.kind == KIND_WRITE) && (rgn == RGN_AUD_SEL)) ?
		item.value[3:0] : select_q;
	assign t_sum    = {1'b0, prescale_q} + {2'b00, item.cycles};
	assign step     = (item.kind == KIND_TICK) && (t_sum > 4'd5);
	assign prescale_d = (item.kind != KIND_TICK) ? prescale_q :
		(step ? 3'(t_sum - 4'd6) : t_sum[2:0]);

	always_comb begin
		for (int j = 0; j < TONE_CHANNELS; j++) begin
			period_d[j]  = period_q[j];
			enable_d[j]  = enable_q[j];
			volume_d[j]  = volume_q[j];
			counter_d[j] = counter_q[j];
			phase_d[j]   = phase_q[j];
			next_cnt[j]  = {1'b0, counter_q[j]} + 13'd1;
			if (data_wr) begin
				if (select_q <= SEL_PERIOD_LAST && select_q[2:1] == 2'(j)) begin
					if (select_q[0]) begin
						period_d[j] = {item.value[3:0], period_q[j][7:0]};
					end else begin
						period_d[j] = {period_q[j][11:8], item.value};
					end
				end
				if (select_q == SEL_ENABLE) begin
					enable_d[j] = ~item.value[j];
				end
				if (select_q >= SEL_VOL_FIRST && select_q <= SEL_VOL_LAST &&
					select_q[1:0] == 2'(j)) begin
					volume_d[j] = item.value[3:0];
				end
			end
			if (step && period_q[j] != 12'd0) begin
				if (next_cnt[j] >= {1'b0, period_q[j]}) begin
					counter_d[j] = '0;
					phase_d[j]   = phase_q[j] + 4'd1;
				end else begin
					counter_d[j] = next_cnt[j][11:0];
				end
			end
		end
	end

	always_comb begin
		level_acc = '0;
		for (int j = 0; j < TONE_CHANNELS; j++) begin
			if (enable_d[j] && phase_d[j][3]) begin
				level_acc = level_acc + vol_scaled(volume_d[j]);
			end
		end
	end

	assign audio_level = level_acc[17:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_q   <= '0;
			prescale_q <= '0;
			for (int j = 0; j < TONE_CHANNELS; j++) begin
				period_q[j]  <= '0;
				enable_q[j]  <= 1'b0;
				volume_q[j]  <= '0;
				counter_q[j] <= '0;
				phase_q[j]   <= '0;
			end
		end else if (advance) begin
			select_q   <= select_d;
			prescale_q <= prescale_d;
			for (int j = 0; j < TONE_CHANNELS; j++) begin
				period_q[j]  <= period_d[j];
				enable_q[j]  <= enable_d[j];
				volume_q[j]  <= volume_d[j];
				counter_q[j] <= counter_d[j];
				phase_q[j]   <= phase_d[j];
			end
		end
	end

endmodule

FILE: hw/rtl/cartridge_bank_mapper_with_irq_and_tones.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq_and_tones: bank mapper, IRQ timer, tones
// Input register, then decode and state update into the result register.
// Throughput 1 item per cycle unless out_ready stalls a held result; set by the single update pass after the input.
// Async reset restores the power-on banks and clears IRQ and tone state.
// ----------------------------------------------------------------------------
`include "cartridge_bank_mapper_with_irq_and_tones_macros.svh"

module cartridge_bank_mapper_with_irq_and_tones #(
	parameter int TONE_CHANNELS = cbm_pkg::TONE_CHANNELS_DEF,
	parameter int VOL_FRAC_BITS = cbm_pkg::VOL_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] address,
	input  logic [7:0]  value,
	input  logic [1:0]  cycles,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  target,
	output logic [18:0] rom_address,
	output logic        irq_line,
	output logic [1:0]  mirroring,
	output logic [17:0] audio_level,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);
	import cbm_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic        valid_s2;
	logic [2:0]  target_s2;
	logic [18:0] rom_s2;
	logic        irq_s2;
	logic [1:0]  mirror_s2;
	logic [17:0] level_s2;

	logic        advance;
	logic        cfg_we;
	irq_wr_t     irq_wr;
	logic [2:0]  target_d;
	logic [18:0] rom_d;
	logic        irq_d;
	logic [1:0]  mirror_d;
	logic [17:0] level_d;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid;

	// hold the accepted item until the update pass can run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{kind: kind_t'(kind), address: address, value: value, cycles: cycles};
		end
	end

	cbm_map u_map (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.item        (item_s1),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.target      (target_d),
		.rom_address (rom_d),
		.mirroring   (mirror_d),
		.irq_wr      (irq_wr)
	);

	cbm_irq u_irq (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (item_s1),
		.irq_wr   (irq_wr),
		.irq_line (irq_d)
	);

	cbm_tone #(
		.TONE_CHANNELS (TONE_CHANNELS),
		.VOL_FRAC_BITS (VOL_FRAC_BITS)
	) u_tone (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.item        (item_s1),
		.audio_level (level_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			target_s2 <= target_d;
			rom_s2    <= rom_d;
			irq_s2    <= irq_d;
			mirror_s2 <= mirror_d;
			level_s2  <= level_d;
		end
	end

	assign out_valid   = valid_s2;
	assign target      = target_s2;
	assign rom_address = rom_s2;
	assign irq_line    = irq_s2;
	assign mirroring   = mirror_s2;
	assign audio_level = level_s2;

	`CBM_ASSERT_NEXT(a_advance_fills_result, advance, valid_s2)
	`CBM_ASSERT_SAME(a_empty_result_takes_input, !valid_s2, in_ready)
	`CBM_ASSERT_SAME(a_rom_zero_off_rom, valid_s2 && target_s2 != TGT_PRG && target_s2 != TGT_CHR, rom_s2 == 19'd0)
	`CBM_ASSERT_SAME(a_chr_fits_18_bits, valid_s2 && target_s2 == TGT_CHR, !rom_s2[18])

endmodule

FILE: tb/cartridge_bank_mapper_with_irq_and_tones_test.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_with_irq_and_tones_test
// Self-checking bench for the bank mapper. CPU writes, CPU reads, pattern
// fetches and clock ticks enter under random gaps while results leave under
// random back-pressure. A predictor tracks banks, IRQ and tone state, and
// each result is compared field by field over several ROM size settings.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_with_irq_and_tones_test;
	import cbm_pkg::*;

	localparam int TONES = TONE_CHANNELS_DEF;
	localparam int NUM_SETTINGS = 6;
	localparam int RANDOM_PER_SETTING = 62;
	localparam int STALL_LIMIT = 200;
	localparam int DIRECTED_ROWS = 27;

	localparam logic [3:0] PRG_LOG2_SET [NUM_SETTINGS] = '{4'd5, 4'd0, 4'd6, 4'd7, 4'd3, 4'd2};
	localparam logic [3:0] CHR_LOG2_SET [NUM_SETTINGS] = '{4'd8, 4'd0, 4'd8, 4'd15, 4'd4, 4'd9};

	localparam int unsigned TONE_WEIGHT [16] = '{
		0, 362, 511, 722, 1019, 1440, 2033, 2872,
		4057, 5731, 8095, 11435, 16153, 22816, 32228, 45524
	};

	typedef struct packed {
		target_t     tgt;
		logic [18:0] rom;
		logic        irq;
		logic [1:0]  mir;
		logic [17:0] lvl;
	} bus_result_t;

	typedef struct packed {
		item_t       it;
		logic        typed;
		bus_result_t want;
	} directed_row_t;

	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{'{KIND_READ,  16'h8000, 8'h00, 2'd0}, 1'b1, '{TGT_PRG,  19'h00000, 1'b0, 2'd0, 18'd0}},
		'{'{KIND_READ,  16'hFFFF, 8'h00, 2'd0}, 1'b1, '{TGT_PRG,  19'h3FFFF, 1'b0, 2'd0, 18'd0}},
		'{'{KIND_READ,  16'hC000, 8'h00, 2'd0}, 1'b1, '{TGT_PRG,  19'h02000, 1'b0, 2'd0, 18'd0}},
		'{'{KIND_READ,  16'h6000, 8'h00, 2'd0}, 1'b1, '{TGT_PRG,  19'h00000, 1'b0, 2'd0, 18'd0}},
		'{'{KIND_FETCH, 16'h0000, 8'h00, 2'd0}, 1'b1, '{TGT_CHR,  19'h00000, 1'b0, 2'd0, 18'd0}},
		'{'{KIND_FETCH, 16'hFFFF, 8'h00, 2'd0}, 1'b1, '{TGT_CHR,  19'h01FFF, 1'b0, 2'd0, 18'd0}},
		'{'{KIND_TICK,  16'h0000, 8'h00, 2'd3}, 1'b1, '{TGT_NONE, 19'h00000, 1'b0, 2'd0, 18'd0}},
		'{'{KIND_WRITE, 16'h6000, 8'hFF, 2'd0}, 1'b1, '{TGT_NONE, 19'h00000, 1'b0, 2'd0, 18'd0}},
		'{'{KIND_WRITE, 16'h9FFF, 8'hFE, 2'd0}, 1'b1, '{TGT_NONE, 19'h00000, 1'b0, 2'd0, 18'd0}},
		'{'{KIND_WRITE, 16'hBFFF, 8'h01, 2'd0}, 1'b0, '0},
		'{'{KIND_WRITE, 16'h8000, 8'h0D, 2'd0}, 1'b0, '0},
		'{'{KIND_WRITE, 16'hA000, 8'h81, 2'd0}, 1'b0, '0},
		'{'{KIND_TICK,  16'h0000, 8'h00, 2'd3}, 1'b0, '0},
		'{'{KIND_TICK,  16'h0000, 8'h00, 2'd3}, 1'b0, '0},
		'{'{KIND_WRITE, 16'hA000, 8'h00, 2'd0}, 1'b1, '{TGT_NONE, 19'h00000, 1'b0, 2'd0, 18'd0}},
		'{'{KIND_WRITE, 16'h8000, 8'h08, 2'd0}, 1'b0, '0},
		'{'{KIND_WRITE, 16'hA000, 8'hC0, 2'd0}, 1'b0, '0},
		'{'{KIND_WRITE, 16'h7FFF, 8'h55, 2'd0}, 1'b0, '0},
		'{'{KIND_WRITE, 16'hC000, 8'h07, 2'd0}, 1'b0, '0},
		'{'{KIND_WRITE, 16'hE000, 8'hF8, 2'd0}, 1'b0, '0},
		'{'{KIND_WRITE, 16'hDFFF, 8'h08, 2'd0}, 1'b0, '0},
		'{'{KIND_WRITE, 16'hFFFF, 8'h1F, 2'd0}, 1'b0, '0},
		'{'{KIND_WRITE, 16'hC000, 8'hFF, 2'd0}, 1'b0, '0},
		'{'{KIND_WRITE, 16'hE000, 8'hAA, 2'd0}, 1'b0, '0},
		'{'{KIND_WRITE, 16'hC000, 8'h00, 2'd0}, 1'b0, '0},
		'{'{KIND_WRITE, 16'hE000, 8'h01, 2'd0}, 1'b0, '0},
		'{'{KIND_TICK,  16'h0000, 8'h00, 2'd0}, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  kind = '0;
	logic [15:0] address = '0;
	logic [7:0]  value = '0;
	logic [1:0]  cycles = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  target;
	logic [18:0] rom_address;
	logic        irq_line;
	logic [1:0]  mirroring;
	logic [17:0] audio_level;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [3:0]  cfg_data = '0;

	logic        row_typed = 1'b0;
	bus_result_t row_want = '0;

	// predicted mapper state
	logic [2:0]  prg_log2;
	logic [3:0]  chr_log2;
	logic [3:0]  cmd_sel;
	logic [7:0]  wram_mode;
	logic [7:0]  prg_page [3];
	logic [7:0]  chr_page [CHR_SLOTS];
	logic [1:0]  mirror;
	logic [1:0]  irq_ctl;
	logic [15:0] irq_cnt;
	logic        irq_flag;
	logic [1:0]  irq_div;
	logic [2:0]  snd_div;
	logic [3:0]  snd_sel;
	logic [11:0] tone_len [TONES];
	logic        tone_on [TONES];
	logic [3:0]  tone_vol [TONES];
	logic [11:0] tone_pos [TONES];
	logic [3:0]  tone_step [TONES];

	bus_result_t awaited_results [$];
	item_t       plan_q [$];
	item_t       taken;
	bus_result_t predicted, seen, head;

	int mismatches = 0;
	int quiet_cycles = 0;
	int items_sent = 0;
	int results_seen = 0;
	int irq_results = 0;
	int loud_results = 0;
	bit in_calm = 0;

	cartridge_bank_mapper_with_irq_and_tones uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.address(address),
		.value(value),
		.cycles(cycles),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.target(target),
		.rom_address(rom_address),
		.irq_line(irq_line),
		.mirroring(mirroring),
		.audio_level(audio_level),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic item_t bus_item(input kind_t k, input logic [15:0] a,
			input logic [7:0] v, input logic [1:0] c);
		item_t it;
		it.kind = k;
		it.address = a;
		it.value = v;
		it.cycles = c;
		return it;
	endfunction

	function automatic logic [18:0] prg_rom_byte(input logic [7:0] bank, input logic [15:0] a);
		int unsigned lg;
		lg = (prg_log2 > 3'd6) ? 6 : prg_log2;
		return 19'(((bank & ((32'd1 << lg) - 1)) << 13) | a[12:0]);
	endfunction

	function automatic bus_result_t advance_mapper(input item_t it);
		bus_result_t r;
		logic [7:0] bank;
		int unsigned t, lg, lvl;
		int ch;
		r = '0;
		r.tgt = TGT_NONE;
		case (it.kind)
			KIND_WRITE: begin
				case (it.address[15:13])
					RGN_WRAM: begin
						if (wram_mode[7:6] == 2'b11)
							r.tgt = TGT_WRAM;
					end
					RGN_CMD_SEL: cmd_sel = it.value[3:0];
					RGN_CMD_DATA: begin
						if (cmd_sel <= CMD_CHR_LAST)
							chr_page[cmd_sel[2:0]] = it.value;
						else if (cmd_sel == CMD_RAM_MODE)
							wram_mode = it.value;
						else if (cmd_sel <= CMD_PRG2)
							prg_page[2'(cmd_sel - CMD_PRG0)] = it.value;
						else if (cmd_sel == CMD_MIRROR)
							mirror = it.value[1:0];
						else if (cmd_sel == CMD_IRQ_CTRL) begin
							irq_ctl = {it.value[7], it.value[0]};
							irq_flag = 1'b0;
						end else if (cmd_sel == CMD_IRQ_LO)
							irq_cnt[7:0] = it.value;
						else
							irq_cnt[15:8] = it.value;
					end
					RGN_AUD_SEL: snd_sel = it.value[3:0];
					RGN_AUD_DATA: begin
						if (snd_sel <= SEL_PERIOD_LAST) begin
							ch = snd_sel[2:1];
							if (snd_sel[0])
								tone_len[ch][11:8] = it.value[3:0];
							else
								tone_len[ch][7:0] = it.value;
						end else if (snd_sel == SEL_ENABLE) begin
							for (ch = 0; ch < TONES; ch++)
								tone_on[ch] = ~it.value[ch];
						end else if (snd_sel >= SEL_VOL_FIRST && snd_sel <= SEL_VOL_LAST) begin
							tone_vol[2'(snd_sel - SEL_VOL_FIRST)] = it.value[3:0];
						end
					end
					default: ;
				endcase
			end
			KIND_READ: begin
				if (it.address[15]) begin
					if (it.address[14:13] == 2'd3)
						bank = 8'hFF;
					else
						bank = prg_page[it.address[14:13]];
					r.tgt = TGT_PRG;
					r.rom = prg_rom_byte(bank, it.address);
				end else if (it.address[15:13] == RGN_WRAM) begin
					if (wram_mode[6]) begin
						r.tgt = wram_mode[7] ? TGT_WRAM : TGT_ZERO;
					end else begin
						r.tgt = TGT_PRG;
						r.rom = prg_rom_byte({2'b00, wram_mode[5:0]}, it.address);
					end
				end
			end
			KIND_FETCH: begin
				lg = (chr_log2 > 4'd8) ? 8 : chr_log2;
				bank = chr_page[it.address[12:10]];
				r.tgt = TGT_CHR;
				r.rom = 19'(((bank & ((32'd1 << lg) - 1)) << 10) | it.address[9:0]);
			end
			default: begin
				t = irq_div + it.cycles;
				while (t > 2) begin
					if (irq_ctl[1]) begin
						if (irq_cnt == 16'd0 && irq_ctl[0])
							irq_flag = 1'b1;
						irq_cnt = irq_cnt - 16'd1;
					end
					t -= 3;
				end
				irq_div = 2'(t);
				t = snd_div + it.cycles;
				while (t > 5) begin
					t -= 6;
					for (ch = 0; ch < TONES; ch++) begin
						if (tone_len[ch] != 12'd0) begin
							if (32'(tone_pos[ch]) + 1 >= 32'(tone_len[ch])) begin
								tone_pos[ch] = '0;
								tone_step[ch] = tone_step[ch] + 4'd1;
							end else begin
								tone_pos[ch] = tone_pos[ch] + 12'd1;
							end
						end
					end
				end
				snd_div = 3'(t);
			end
		endcase
		lvl = 0;
		for (ch = 0; ch < TONES; ch++) begin
			if (tone_on[ch] && tone_step[ch][3])
				lvl += TONE_WEIGHT[tone_vol[ch]];
		end
		r.irq = irq_flag;
		r.mir = mirror;
		r.lvl = 18'(lvl);
		return r;
	endfunction

	task automatic report_miss(input string why, input bus_result_t want, input bus_result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: want target %0d rom %h irq %b mirror %0d level %0d, got target %0d rom %h irq %b mirror %0d level %0d",
				why, want.tgt, want.rom, want.irq, want.mir, want.lvl,
				got.tgt, got.rom, got.irq, got.mir, got.lvl);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_PRG_LOG2)
					prg_log2 = cfg_data[2:0];
				else
					chr_log2 = cfg_data;
			end
			if (in_valid && in_ready) begin
				taken.kind = kind_t'(kind);
				taken.address = address;
				taken.value = value;
				taken.cycles = cycles;
				predicted = advance_mapper(taken);
				awaited_results.push_back(row_typed ? row_want : predicted);
			end
			if (out_valid && out_ready) begin
				seen.tgt = target_t'(target);
				seen.rom = rom_address;
				seen.irq = irq_line;
				seen.mir = mirroring;
				seen.lvl = audio_level;
				results_seen++;
				if (irq_line)
					irq_results++;
				if (audio_level != 18'd0)
					loud_results++;
				if (awaited_results.size() == 0) begin
					report_miss("result with nothing awaited", '0, seen);
				end else begin
					head = awaited_results.pop_front();
					if (seen.tgt !== head.tgt || seen.rom !== head.rom || seen.irq !== head.irq
							|| seen.mir !== head.mir || seen.lvl !== head.lvl)
						report_miss("result mismatch", head, seen);
				end
			end
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
						quiet_cycles, awaited_results.size());
					$display("cartridge_bank_mapper_with_irq_and_tones_test failed");
					$finish;
				end
			end
		end
	end

	initial begin : result_sink
		int stall;
		bit calm;
		calm = 0;
		forever begin
			stall = calm ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if ($urandom_range(0, 24) == 0)
				calm = !calm;
		end
	end

	task automatic send_item(input item_t it, input logic typed_row, input bus_result_t want_row);
		int gap;
		in_valid <= 1'b1;
		kind <= it.kind;
		address <= it.address;
		value <= it.value;
		cycles <= it.cycles;
		row_typed <= typed_row;
		row_want <= want_row;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if ($urandom_range(0, 19) == 0)
			in_calm = !in_calm;
		gap = in_calm ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_cfg(input logic idx, input logic [3:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic drain();
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic plan_random(output int counted);
		int r, n;
		logic [3:0] code;
		logic [7:0] d;
		logic [15:0] a;
		r = $urandom_range(0, 99);
		counted = 1;
		if (r < 25) begin
			a = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(16'h6000, 16'hFFFF));
			plan_q.push_back(bus_item(KIND_READ, a, 8'($urandom), 2'($urandom)));
		end else if (r < 35) begin
			plan_q.push_back(bus_item(KIND_FETCH, 16'($urandom), 8'($urandom), 2'($urandom)));
		end else if (r < 62) begin
			n = $urandom_range(1, 6);
			counted = n;
			repeat (n)
				plan_q.push_back(bus_item(KIND_TICK, 16'($urandom), 8'($urandom),
					$urandom_range(0, 1) ? 2'd3 : 2'($urandom)));
		end else if (r < 78) begin
			code = 4'($urandom);
			case (code)
				CMD_IRQ_CTRL: d = ($urandom_range(0, 2) != 0) ? (8'($urandom) | 8'h81) : 8'($urandom);
				CMD_IRQ_LO:   d = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 12)) : 8'($urandom);
				CMD_IRQ_HI:   d = ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom);
				default:      d = 8'($urandom);
			endcase
			counted = 2;
			plan_q.push_back(bus_item(KIND_WRITE, {RGN_CMD_SEL, 13'($urandom)},
				{4'($urandom), code}, 2'($urandom)));
			plan_q.push_back(bus_item(KIND_WRITE, {RGN_CMD_DATA, 13'($urandom)}, d, 2'($urandom)));
		end else if (r < 94) begin
			code = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 10));
			if (code <= SEL_PERIOD_LAST && code[0])
				d = ($urandom_range(0, 7) != 0) ? {4'($urandom), 4'h0} : 8'($urandom);
			else if (code <= SEL_PERIOD_LAST)
				d = ($urandom_range(0, 4) < 3) ? 8'($urandom_range(1, 4)) : 8'($urandom);
			else
				d = 8'($urandom);
			counted = 2;
			plan_q.push_back(bus_item(KIND_WRITE, {RGN_AUD_SEL, 13'($urandom)},
				{4'($urandom), code}, 2'($urandom)));
			plan_q.push_back(bus_item(KIND_WRITE, {RGN_AUD_DATA, 13'($urandom)}, d, 2'($urandom)));
		end else begin
			a = 16'($urandom);
			counted = (a >= 16'h6000) ? 1 : 0;
			plan_q.push_back(bus_item(KIND_WRITE, a, 8'($urandom), 2'($urandom)));
		end
	endtask

	initial begin : stimulus
		int setting, i, budget, counted;
		prg_log2 = 3'd5;
		chr_log2 = 4'd8;
		cmd_sel = '0;
		wram_mode = '0;
		prg_page[0] = 8'd0;
		prg_page[1] = 8'd0;
		prg_page[2] = 8'd1;
		for (i = 0; i < CHR_SLOTS; i++)
			chr_page[i] = 8'(i);
		mirror = '0;
		irq_ctl = '0;
		irq_cnt = '0;
		irq_flag = 1'b0;
		irq_div = '0;
		snd_div = '0;
		snd_sel = '0;
		for (i = 0; i < TONES; i++) begin
			tone_len[i] = '0;
			tone_on[i] = 1'b0;
			tone_vol[i] = '0;
			tone_pos[i] = '0;
			tone_step[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (setting = 0; setting < NUM_SETTINGS; setting++) begin
			drain();
			write_cfg(CFG_PRG_LOG2, PRG_LOG2_SET[setting]);
			write_cfg(CFG_CHR_LOG2, CHR_LOG2_SET[setting]);
			cfg_valid <= 1'b0;
			if (setting == 0) begin
				for (i = 0; i < DIRECTED_ROWS; i++)
					send_item(DIRECTED[i].it, DIRECTED[i].typed, DIRECTED[i].want);
			end
			budget = 0;
			while (budget < RANDOM_PER_SETTING) begin
				plan_random(counted);
				budget += counted;
				while (plan_q.size() != 0)
					send_item(plan_q.pop_front(), 1'b0, '0);
			end
			in_valid <= 1'b0;
		end
		drain();
		$display("%0d bus items (%0d directed) over %0d ROM size settings, %0d results compared",
			items_sent, DIRECTED_ROWS, NUM_SETTINGS, results_seen);
		$display("%0d results with the IRQ line high, %0d with tone output, %0d mismatches",
			irq_results, loud_results, mismatches);
		if (mismatches == 0)
			$display("cartridge_bank_mapper_with_irq_and_tones_test passed");
		else
			$display("cartridge_bank_mapper_with_irq_and_tones_test failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/cbm_pkg.sv
hw/rtl/cbm_map.sv
hw/rtl/cbm_irq.sv
hw/rtl/cbm_tone.sv
hw/rtl/cartridge_bank_mapper_with_irq_and_tones.sv
tb/cartridge_bank_mapper_with_irq_and_tones_test.sv
